// ----- src/itf_pkg.sv -----
// shared types, codes and helpers of the integer to text formatter
`default_nettype none

package itf_pkg;

  // conversion kinds
  typedef enum logic [1:0] {
    FUNC_UDEC = 2'd0,
    FUNC_SDEC = 2'd1,
    FUNC_HEX  = 2'd2,
    FUNC_PTR  = 2'd3
  } func_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN_LEAD,
    ST_PAD,
    ST_SIGN_TRAIL,
    ST_BODY
  } state_e;

  // ascii codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // digit buffer depth: ten decimal digits of a 32-bit value
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DIG_IDX_W  = 4;

  // ceil(2^35 / 10), quotient is the product shifted right by 35
  localparam logic [31:0] RECIP_TEN = 32'hcccc_cccd;
  localparam int unsigned RECIP_SHIFT = 35;

  // pointer digit counts minus one, and the colon position of the long form
  localparam logic [DIG_IDX_W-1:0] PTR_LAST_SHORT = 4'd3;
  localparam logic [DIG_IDX_W-1:0] PTR_LAST_LONG  = 4'd7;
  localparam logic [DIG_IDX_W-1:0] PTR_COLON_POS  = 4'd4;

  // upper-case hex character of a digit value
  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib <= 4'd9) begin
      ch = CH_ZERO + {4'd0, nib};
    end else begin
      ch = CH_UPPER + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- src/itf_if.sv -----
// channel interfaces of the formatter: value requests in, characters out
`default_nettype none

interface itf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] value;
  logic        long_form;
  logic        zero_pad;
  logic [6:0]  width;

  modport source (output valid, func, value, long_form, zero_pad, width, input ready);
  modport sink   (input valid, func, value, long_form, zero_pad, width, output ready);
endinterface

interface itf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

`default_nettype wire

// ----- src/integer_to_text_formatter_core.sv -----
// integer to text formatter: value in, ascii characters out one per transaction
//
// Usage:
//   in_if  (sink): one transaction carries func, value, long_form, zero_pad and
//          width. ready is high only while the block is idle.
//   out_if (source): one character per transaction, last marks the final
//          character of the item's text.
// Flow per item:
//   the request is taken while idle, then the shared digit unit makes one
//   digit per cycle (a multiply by the reciprocal of ten for decimal, a
//   4-bit shift for hex and pointer), 1 to 10 digits, then one character
//   per cycle goes through a registered output stage while the receiver is
//   ready, 1 to 64 characters. The next request can be taken while the
//   last character still waits in the output register.
// Reset clears the sequencer and the output valid; no memory needs clearing.
// When the receiver stalls, the current character holds in the output
// register and the sequencer waits; nothing is lost or repeated.
`default_nettype none

module integer_to_text_formatter_core #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itf_in_if.sink     in_if,
  itf_out_if.source  out_if
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DW = itf_pkg::DIG_IDX_W;

  itf_pkg::state_e state_q, state_d;
  itf_pkg::func_e  func_q, func_d;
  logic [31:0]     val_q, val_d;
  logic            long_q, long_d;
  logic            zpad_q, zpad_d;
  logic            minus_q, minus_d;
  logic [CW-1:0]   w_q, w_d;
  logic [CW-1:0]   pad_q, pad_d;
  logic [DW-1:0]   cnt_q, cnt_d;
  logic            colon_q, colon_d;
  logic [7:0]      buf_q [itf_pkg::MAX_DIGITS];

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_char_q, out_char_d;
  logic            out_last_q, out_last_d;

  // shared digit unit
  logic [63:0]     prod;
  logic [28:0]     quot;
  logic [31:0]     quot_x10;
  logic [31:0]     rem;
  logic [3:0]      digit;
  logic [31:0]     val_next;
  logic            conv_done;
  logic [7:0]      digit_char;

  logic            emit_ok;

  assign in_if.ready     = (state_q == itf_pkg::ST_IDLE);
  assign out_if.valid    = out_valid_q;
  assign out_if.char_out = out_char_q;
  assign out_if.last     = out_last_q;

  assign emit_ok = !out_valid_q || out_if.ready;

  // one digit per cycle: divide by ten via reciprocal, or take a nibble
  always_comb begin
    prod     = val_q * itf_pkg::RECIP_TEN;
    quot     = prod[63:itf_pkg::RECIP_SHIFT];
    quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    rem      = val_q - quot_x10;
    if (func_q inside {itf_pkg::FUNC_HEX, itf_pkg::FUNC_PTR}) begin
      digit    = val_q[3:0];
      val_next = {4'd0, val_q[31:4]};
    end else begin
      digit    = rem[3:0];
      val_next = {3'd0, quot};
    end
    digit_char = itf_pkg::hex_ascii(digit);
    if (func_q == itf_pkg::FUNC_PTR) begin
      conv_done = (cnt_q == (long_q ? itf_pkg::PTR_LAST_LONG : itf_pkg::PTR_LAST_SHORT));
    end else begin
      conv_done = (val_next == 32'd0);
    end
  end

  // sequencer: next state, counters and output stage
  always_comb begin
    logic [31:0] raw;
    logic        neg;
    logic [DW-1:0] ndig;
    int          len;

    state_d     = state_q;
    func_d      = func_q;
    val_d       = val_q;
    long_d      = long_q;
    zpad_d      = zpad_q;
    minus_d     = minus_q;
    w_d         = w_q;
    pad_d       = pad_q;
    cnt_d       = cnt_q;
    colon_d     = colon_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    raw         = '0;
    neg         = 1'b0;
    ndig        = '0;
    len         = 0;

    case (state_q)
      itf_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          raw = in_if.long_form ? in_if.value : {16'd0, in_if.value[15:0]};
          neg = (itf_pkg::func_e'(in_if.func) == itf_pkg::FUNC_SDEC) &&
                (in_if.long_form ? raw[31] : raw[15]);
          func_d  = itf_pkg::func_e'(in_if.func);
          long_d  = in_if.long_form;
          zpad_d  = in_if.zero_pad;
          minus_d = neg;
          if (neg) begin
            val_d = in_if.long_form ? (32'd0 - raw) : {16'd0, 16'd0 - raw[15:0]};
          end else begin
            val_d = raw;
          end
          if (int'(in_if.width) > int'(MAX_WIDTH)) begin
            w_d = CW'(MAX_WIDTH);
          end else begin
            w_d = CW'(in_if.width);
          end
          cnt_d   = '0;
          colon_d = 1'b0;
          state_d = itf_pkg::ST_CONV;
        end
      end

      itf_pkg::ST_CONV: begin
        ndig  = cnt_q + 1'b1;
        cnt_d = ndig;
        val_d = val_next;
        if (conv_done) begin
          len = int'(ndig) + (minus_q ? 1 : 0);
          if (func_q != itf_pkg::FUNC_PTR && int'(w_q) > len) begin
            pad_d = CW'(int'(w_q) - len);
          end else begin
            pad_d = '0;
          end
          if (minus_q && zpad_q) begin
            state_d = itf_pkg::ST_SIGN_LEAD;
          end else if (pad_d != '0) begin
            state_d = itf_pkg::ST_PAD;
          end else if (minus_q) begin
            state_d = itf_pkg::ST_SIGN_TRAIL;
          end else begin
            state_d = itf_pkg::ST_BODY;
          end
        end
      end

      itf_pkg::ST_SIGN_LEAD: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_char_d  = itf_pkg::CH_MINUS;
          out_last_d  = 1'b0;
          state_d     = (pad_q != '0) ? itf_pkg::ST_PAD : itf_pkg::ST_BODY;
        end
      end

      itf_pkg::ST_PAD: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_char_d  = zpad_q ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE;
          out_last_d  = 1'b0;
          pad_d       = pad_q - 1'b1;
          if (pad_q == CW'(1)) begin
            state_d = (minus_q && !zpad_q) ? itf_pkg::ST_SIGN_TRAIL : itf_pkg::ST_BODY;
          end
        end
      end

      itf_pkg::ST_SIGN_TRAIL: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_char_d  = itf_pkg::CH_MINUS;
          out_last_d  = 1'b0;
          state_d     = itf_pkg::ST_BODY;
        end
      end

      itf_pkg::ST_BODY: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          // long pointer gets a colon between the two halves
          if (func_q == itf_pkg::FUNC_PTR && long_q &&
              cnt_q == itf_pkg::PTR_COLON_POS && !colon_q) begin
            out_char_d = itf_pkg::CH_COLON;
            out_last_d = 1'b0;
            colon_d    = 1'b1;
          end else begin
            out_char_d = buf_q[cnt_q - 1'b1];
            out_last_d = (cnt_q == DW'(1));
            cnt_d      = cnt_q - 1'b1;
            if (cnt_q == DW'(1)) begin
              state_d = itf_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = itf_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    val_q      <= val_d;
    long_q     <= long_d;
    zpad_q     <= zpad_d;
    minus_q    <= minus_d;
    w_q        <= w_d;
    pad_q      <= pad_d;
    cnt_q      <= cnt_d;
    colon_q    <= colon_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // digit buffer, filled least significant digit first
  always_ff @(posedge clk_i) begin
    if (state_q == itf_pkg::ST_CONV) begin
      buf_q[cnt_q] <= digit_char;
    end
  end

  // an accepted request always starts the digit loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> state_q == itf_pkg::ST_CONV)
    else $error("accepted request did not start conversion");

  // while idle, a character still waiting must be the end of the text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itf_pkg::ST_IDLE && out_valid_q |-> out_last_q)
    else $error("idle with a non-final character pending");

  // the final character returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_d && out_last_d && emit_ok && state_q == itf_pkg::ST_BODY
    |=> state_q == itf_pkg::ST_IDLE)
    else $error("final character sent without returning to idle");

  // digit count stays within the buffer during conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itf_pkg::ST_CONV |-> int'(cnt_q) < int'(itf_pkg::MAX_DIGITS))
    else $error("digit buffer overflow");

endmodule

`default_nettype wire

// ----- tb/integer_to_text_formatter_core_test.sv -----
// self-checking testbench of the integer to text formatter core
`default_nettype none

module integer_to_text_formatter_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_MAX = 64;

  // one expected character of formatted text
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic clk;
  logic rst_n;

  itf_in_if  req_ch ();
  itf_out_if char_ch ();

  text_char_t pending_text[$];
  int         errors;
  int         items_sent;
  int         chars_checked;
  int         kind_count[4];
  bit         calm;
  int         stall_left;

  integer_to_text_formatter_core #(
    .MAX_WIDTH(FIELD_MAX)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (req_ch),
    .out_if(char_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // upper-case hex character of one nibble
  function automatic logic [7:0] nibble_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return itf_pkg::CH_ZERO + 8'(d);
    end
    return itf_pkg::CH_UPPER + 8'(d) - 8'd10;
  endfunction

  // build the expected text of one request and queue it
  function automatic void format_value(input itf_pkg::func_e kind, input logic [31:0] raw,
                                       input bit lng, input bit zp,
                                       input logic [6:0] wd);
    logic [31:0]  mag;
    logic [7:0]   body[$];
    logic [7:0]   text[$];
    bit           neg;
    int unsigned  field;
    int unsigned  ndig;
    int unsigned  len;
    int unsigned  pad;
    mag   = lng ? raw : {16'h0, raw[15:0]};
    field = (wd > FIELD_MAX) ? FIELD_MAX : wd;
    neg   = 1'b0;
    if (kind == itf_pkg::FUNC_PTR) begin
      // fixed digit count, colon in the middle of the long form
      ndig = lng ? 8 : 4;
      for (int i = 0; i < ndig; i++) begin
        if (lng && i == 4) begin
          text.push_back(itf_pkg::CH_COLON);
        end
        text.push_back(nibble_char(4'(mag >> ((ndig - 1 - i) * 4))));
      end
    end else begin
      if (kind == itf_pkg::FUNC_SDEC && (lng ? mag[31] : mag[15])) begin
        neg = 1'b1;
        mag = lng ? 32'd0 - mag : {16'h0, 16'd0 - mag[15:0]};
      end
      // digits, least significant first
      do begin
        if (kind == itf_pkg::FUNC_HEX) begin
          body.push_back(nibble_char(mag[3:0]));
          mag = mag >> 4;
        end else begin
          body.push_back(itf_pkg::CH_ZERO + 8'(mag % 10));
          mag = mag / 10;
        end
      end while (mag != 0);
      len = body.size() + neg;
      pad = (field > len) ? field - len : 0;
      // minus goes before zero padding and after space padding
      if (zp) begin
        if (neg) text.push_back(itf_pkg::CH_MINUS);
        repeat (pad) text.push_back(itf_pkg::CH_ZERO);
      end else begin
        repeat (pad) text.push_back(itf_pkg::CH_SPACE);
        if (neg) text.push_back(itf_pkg::CH_MINUS);
      end
      while (body.size() > 0) text.push_back(body.pop_back());
    end
    foreach (text[i]) begin
      pending_text.push_back(text_char_t'{ch: text[i], last: (i == text.size() - 1)});
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && char_ch.valid && char_ch.ready) begin
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %h last %0b",
                 $time, char_ch.char_out, char_ch.last);
        errors++;
      end else begin
        want = pending_text.pop_front();
        if (want.ch !== char_ch.char_out) begin
          $display("%0t: char mismatch: expected %h, actual %h",
                   $time, want.ch, char_ch.char_out);
          errors++;
        end
        if (want.last !== char_ch.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.last, char_ch.last);
          errors++;
        end
        chars_checked++;
      end
    end
  end

  // receiver ready with random stall bursts
  initial begin
    char_ch.ready = 1'b0;
    stall_left    = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        char_ch.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        char_ch.ready = 1'b0;
        stall_left    = $urandom_range(1, 9) - 1;
      end else begin
        char_ch.ready = 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // send one request transaction, with an optional idle gap first
  task automatic send_request(input itf_pkg::func_e kind, input logic [31:0] raw,
                              input bit lng, input bit zp, input logic [6:0] wd);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.func      = kind;
    req_ch.value     = raw;
    req_ch.long_form = lng;
    req_ch.zero_pad  = zp;
    req_ch.width     = wd;
    req_ch.valid     = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    format_value(kind, raw, lng, zp, wd);
    items_sent++;
    kind_count[kind]++;
  endtask

  // drop valid and wait for every queued character
  task automatic drain_text();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
  endtask

  // one request with random fields, mostly narrow fields
  task automatic send_random_request();
    logic [31:0] raw;
    logic [6:0]  wd;
    case ($urandom_range(0, 4))
      0: raw = $urandom;
      1: raw = $urandom_range(0, 20);
      2: raw = $urandom | ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_8000);
      3: raw = $urandom >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 3))
          0: raw = 32'h8000_0000;
          1: raw = 32'h7fff_ffff;
          2: raw = 32'h0000_8000;
          default: raw = 32'hffff_ffff;
        endcase
      end
    endcase
    wd = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(13, 127)) : 7'($urandom_range(0, 12));
    send_request(itf_pkg::func_e'($urandom_range(0, 3)), raw, 1'($urandom), 1'($urandom),
                 wd);
  endtask

  // corners: zero, extremes, sign placement, width saturation, pointer form
  task automatic test_directed_corners();
    send_request(itf_pkg::FUNC_UDEC, 32'h0000_0000, 1'b0, 1'b0, 7'd0);
    send_request(itf_pkg::FUNC_UDEC, 32'hffff_ffff, 1'b0, 1'b0, 7'd0);
    send_request(itf_pkg::FUNC_UDEC, 32'hffff_ffff, 1'b1, 1'b0, 7'd0);
    send_request(itf_pkg::FUNC_SDEC, 32'h0000_8000, 1'b0, 1'b0, 7'd0);
    send_request(itf_pkg::FUNC_SDEC, 32'h8000_0000, 1'b1, 1'b0, 7'd0);
    send_request(itf_pkg::FUNC_SDEC, 32'h7fff_ffff, 1'b1, 1'b0, 7'd0);
    send_request(itf_pkg::FUNC_SDEC, 32'h0000_ffff, 1'b0, 1'b1, 7'd8);
    send_request(itf_pkg::FUNC_SDEC, 32'hffff_ffff, 1'b1, 1'b0, 7'd8);
    send_request(itf_pkg::FUNC_SDEC, 32'h0000_7fff, 1'b0, 1'b1, 7'd3);
    send_request(itf_pkg::FUNC_SDEC, 32'h0000_0000, 1'b1, 1'b1, 7'd127);
    send_request(itf_pkg::FUNC_SDEC, 32'h0000_0000, 1'b0, 1'b0, 7'd1);
    send_request(itf_pkg::FUNC_UDEC, 32'd12345, 1'b0, 1'b0, 7'd64);
    send_request(itf_pkg::FUNC_UDEC, 32'd10, 1'b0, 1'b1, 7'd65);
    send_request(itf_pkg::FUNC_UDEC, 32'd1, 1'b0, 1'b1, 7'd1);
    send_request(itf_pkg::FUNC_HEX, 32'h0000_0000, 1'b0, 1'b0, 7'd0);
    send_request(itf_pkg::FUNC_HEX, 32'hdead_beef, 1'b1, 1'b1, 7'd12);
    send_request(itf_pkg::FUNC_HEX, 32'h1234_abcd, 1'b0, 1'b0, 7'd0);
    send_request(itf_pkg::FUNC_HEX, 32'hffff_ffff, 1'b1, 1'b0, 7'd100);
    send_request(itf_pkg::FUNC_PTR, 32'h0000_0000, 1'b0, 1'b0, 7'd0);
    send_request(itf_pkg::FUNC_PTR, 32'h1234_abcd, 1'b0, 1'b1, 7'd20);
    send_request(itf_pkg::FUNC_PTR, 32'h89ab_cdef, 1'b1, 1'b0, 7'd0);
    send_request(itf_pkg::FUNC_PTR, 32'hffff_ffff, 1'b1, 1'b1, 7'd127);
  endtask

  // random mix with idling on both sides
  task automatic test_random_mix();
    repeat (120) send_random_request();
  endtask

  // sender holds off until all text is out, then resumes
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (10) send_random_request();
      drain_text();
    end
  endtask

  // no idling at all at the end of the run
  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (20) send_random_request();
  endtask

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.func      = itf_pkg::FUNC_UDEC;
    req_ch.value     = '0;
    req_ch.long_form = 1'b0;
    req_ch.zero_pad  = 1'b0;
    req_ch.width     = '0;
    errors           = 0;
    items_sent       = 0;
    chars_checked    = 0;
    kind_count       = '{default: 0};
    calm             = 1'b0;
    rst_n            = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_corners();
    test_random_mix();
    test_drain_pause();
    test_back_to_back();

    drain_text();
    repeat (100) @(posedge clk);

    $display("covered %0d requests (%0d unsigned, %0d signed, %0d hex, %0d pointer)",
             items_sent, kind_count[itf_pkg::FUNC_UDEC], kind_count[itf_pkg::FUNC_SDEC],
             kind_count[itf_pkg::FUNC_HEX], kind_count[itf_pkg::FUNC_PTR]);
    $display("checked %0d characters across padding, sign and width corners",
             chars_checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
